[hdl/hash_message_padder_macros.svh]
// Assertion macros for the message padder.
`ifndef HASH_MESSAGE_PADDER_MACROS_SVH
`define HASH_MESSAGE_PADDER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define HMP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hash_message_padder: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define HMP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hash_message_padder: next-cycle check failed");

`endif

[hdl/hmp_pkg.sv]
`timescale 1ns / 1ps

package hmp_pkg;

	localparam int BLOCK_BYTES = 64;
	localparam int WORD_BYTES  = 8;
	localparam logic [7:0] PAD_BYTE = 8'h80;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_PAD  = 2'b10
	} state_t;

	typedef struct packed {
		logic accept;
		logic pad_load;
	} hmp_cmd_t;

	typedef struct packed {
		logic out_free;
		logic pad_last;
	} hmp_status_t;

endpackage

[hdl/hmp_ctrl.sv]
`timescale 1ns / 1ps

module hmp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                message_end,
	output logic                in_stall,
	input  hmp_pkg::hmp_status_t status,
	output hmp_pkg::hmp_cmd_t    cmd
);

	hmp_pkg::state_t state_q;
	hmp_pkg::state_t state_d;

	always_comb begin
		in_stall     = !((state_q == hmp_pkg::ST_IDLE) && status.out_free);
		cmd.accept   = in_valid && !in_stall;
		cmd.pad_load = (state_q == hmp_pkg::ST_PAD) && status.out_free;
		state_d      = state_q;
		case (state_q)
			hmp_pkg::ST_IDLE: begin
				if (cmd.accept && message_end) begin
					state_d = hmp_pkg::ST_PAD;
				end
			end
			hmp_pkg::ST_PAD: begin
				if (cmd.pad_load && status.pad_last) begin
					state_d = hmp_pkg::ST_IDLE;
				end
			end
			default: state_d = hmp_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hmp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[hdl/hmp_datapath.sv]
`timescale 1ns / 1ps

module hmp_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 length_big_endian,
	input  logic [7:0]           data_byte,
	input  logic                 has_byte,
	input  logic                 message_end,
	input  hmp_pkg::hmp_cmd_t    cmd,
	output hmp_pkg::hmp_status_t status,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [63:0]          block_word,
	output logic                 block_done,
	output logic                 message_done
);

	logic [55:0] partial_q;
	logic [60:0] total_q;
	logic [3:0]  pad_pos_q;
	logic        first_q;
	logic        out_valid_q;
	logic [63:0] word_q;
	logic        blk_q;
	logic        msg_q;

	logic        word_done;
	logic [60:0] total_inc;
	logic [60:0] total_new;
	logic [2:0]  fill;
	logic [3:0]  last_pos;
	logic [63:0] bit_len;
	logic [63:0] len_word;
	logic [63:0] first_word;
	logic [63:0] pad_word;
	logic        byte_load;

	always_comb begin
		word_done = (total_q[2:0] == 3'd7);
		total_inc = total_q + 61'd1;
		total_new = has_byte ? total_inc : total_q;
		byte_load = cmd.accept && has_byte && word_done;
		fill      = total_q[2:0];
		last_pos  = (total_q[5:3] == 3'd7) ? 4'd15 : 4'd7;
		bit_len   = {total_q, 3'b000};
		for (int k = 0; k < hmp_pkg::WORD_BYTES; k++) begin
			len_word[8*k +: 8] = length_big_endian ? bit_len[8*k +: 8]
				: bit_len[8*(hmp_pkg::WORD_BYTES-1-k) +: 8];
		end
		first_word = {partial_q, hmp_pkg::PAD_BYTE} << {3'd7 - fill, 3'b000};
		if (first_q) begin
			pad_word = first_word;
		end else if (pad_pos_q == last_pos) begin
			pad_word = len_word;
		end else begin
			pad_word = '0;
		end
		status.out_free = !out_valid_q || !out_stall;
		status.pad_last = (pad_pos_q == last_pos);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q   <= '0;
			total_q     <= '0;
			pad_pos_q   <= '0;
			first_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				if (has_byte) begin
					partial_q <= word_done ? '0 : {partial_q[47:0], data_byte};
					total_q   <= total_inc;
				end
				if (message_end) begin
					pad_pos_q <= {1'b0, total_new[5:3]};
					first_q   <= 1'b1;
				end
			end
			if (cmd.pad_load) begin
				first_q   <= 1'b0;
				pad_pos_q <= pad_pos_q + 4'd1;
				if (status.pad_last) begin
					partial_q <= '0;
					total_q   <= '0;
				end
			end
			if (byte_load || cmd.pad_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_load) begin
			word_q <= {partial_q, data_byte};
			blk_q  <= (total_q[5:0] == 6'(hmp_pkg::BLOCK_BYTES - 1));
			msg_q  <= 1'b0;
		end else if (cmd.pad_load) begin
			word_q <= pad_word;
			blk_q  <= (pad_pos_q[2:0] == 3'd7);
			msg_q  <= status.pad_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign block_word   = word_q;
	assign block_done   = blk_q;
	assign message_done = msg_q;

endmodule

[hdl/hash_message_padder.sv]
`timescale 1ns / 1ps
// MD5 / SHA-256 message padder.
// Input channel (in_valid, in_stall): one request per message byte with
// data_byte, has_byte and message_end; a request with has_byte low and
// message_end high closes a message without adding a byte.
// Output channel (out_valid, out_stall): 64-bit block words in stream order,
// earliest byte in bits 63:56, block_done on the eighth word of each
// 64-byte block, message_done on the last word of the padding.
// Throughput: one byte request per cycle while the receiver keeps up and no
// padding runs; each eighth byte loads a word into the output register at the
// accepting edge. On message_end 2 to 9 words leave the pad-word counter, one
// per cycle while not stalled; in_stall stays high until the last is loaded.
// An output register parts the channels: a new byte is taken while a word
// waits, as long as that word leaves in the same cycle or none waits.
// Stalling the receiver holds the output word and back-pressures the input.
// Reset clears the byte count, the partial word, the output valid and the
// length byte order (little-endian). The APB register at address 0, bit 0,
// selects big-endian length; write it only while the padder is idle.
`include "hash_message_padder_macros.svh"

module hash_message_padder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        message_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] block_word,
	output logic        block_done,
	output logic        message_done
);

	logic                 length_big_endian_q;
	hmp_pkg::hmp_cmd_t    cmd;
	hmp_pkg::hmp_status_t status;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {31'd0, length_big_endian_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_big_endian_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
			length_big_endian_q <= pwdata[0];
		end
	end

	hmp_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.message_end (message_end),
		.in_stall    (in_stall),
		.status      (status),
		.cmd         (cmd)
	);

	hmp_datapath u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.length_big_endian (length_big_endian_q),
		.data_byte         (data_byte),
		.has_byte          (has_byte),
		.message_end       (message_end),
		.cmd               (cmd),
		.status            (status),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.block_word        (block_word),
		.block_done        (block_done),
		.message_done      (message_done)
	);

endmodule

[hdl/hmp_checker.sv]
`timescale 1ns / 1ps
`include "hash_message_padder_macros.svh"

module hmp_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic message_end,
	input logic out_valid,
	input logic out_stall,
	input logic block_done,
	input logic message_done
);

	`HMP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	`HMP_ASSERT_NOW(a_msg_ends_block, out_valid && message_done, block_done)
	`HMP_ASSERT_NEXT(a_pad_blocks_in, in_valid && !in_stall && message_end, in_stall)

endmodule

bind hash_message_padder hmp_checker u_hmp_checker (.*);
